// File: sv/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// Holds the entry layout, the opcode and status codes and the default depth.
// No dependencies.
package spq_pkg;

    // Default number of entries the queue holds
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int ENTRY_W = ID_W + PRIO_W;
    localparam int STATUS_W = 2;

    // Opcodes carried on the input tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes carried on the output tuser
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // One stored entry: priority in the upper byte, identifier below
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [ID_W-1:0]          id;
    } t_entry;

endpackage

// File: sv/spq_ram.sv
// Entry memory of the stable priority queue: one write port, one read port,
// read data registered.
// Depends on spq_pkg for the entry type.
module spq_ram #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/stable_priority_queue.sv
// Stable priority queue top level: stream handshake, insertion sequencer
// and result register around the entry memory.
// Depends on spq_pkg and spq_ram.
//
// Usage:
//   Input channel (s_axis): tuser is the opcode (enqueue or dequeue), tdata
//   holds the task identifier and signed priority. Output channel (m_axis):
//   tuser is the status (ok, empty, full), tdata the dequeued identifier and
//   priority, zero for enqueues and failed dequeues. Every input transaction
//   gives exactly one output transaction, in order.
//   Entries sit in a circular buffer kept in priority order, front at the
//   head pointer. A dequeue reads the head entry, then passes through S_DEQ
//   and S_DONE. An enqueue walks from the tail toward the head in S_SCAN,
//   one entry per cycle through the single read port, moving each entry of
//   lower priority one place back; it visits at most QUEUE_DEPTH - 1 stored
//   entries, goes to S_INS if it passes the head entry, and ends in S_DONE.
//   S_DONE hands the result to the output register.
//   Full enqueues, enqueues into an empty queue and empty dequeues go
//   straight from S_IDLE to S_DONE.
//   One transaction is worked at a time; o_s_axis_tready is high only while
//   the sequencer is idle. A stalled receiver holds the result register and
//   the finished result of the next transaction waits behind it.
//   Reset empties the queue at once; memory contents are not cleared.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] task_id, [23:16] task_priority
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] out_id, [23:16] out_priority
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_DEQ  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Circular pointer steps
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [AW-1:0]       r_ptr, n_ptr;
    t_entry              r_new, n_new;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    t_entry              r_res_entry, n_res_entry;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    t_entry              r_out_entry, n_out_entry;

    logic            w_s_accept;
    t_entry          w_in_entry;
    logic            w_ram_we;
    logic [AW-1:0]   w_ram_waddr;
    t_entry          w_ram_wdata;
    logic [AW-1:0]   w_ram_raddr;
    t_entry          w_ram_rdata;

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_entry = t_entry'(i_s_axis_tdata);

    spq_ram #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .AW(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    // Sequence one transaction: a read and a write of the same entry in one cycle
    // occur only where the read data goes unused, and each write lands before any later read of it.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ptr        = r_ptr;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_tail;
        w_ram_wdata  = r_new;
        w_ram_raddr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    n_new       = w_in_entry;
                    n_res_entry = '0;
                    if (i_s_axis_tuser == OP_ENQ) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            // Drop the entry, report full
                            n_res_status = STATUS_FULL;
                            n_state      = S_DONE;
                        end else if (r_count == '0) begin
                            // Empty queue: write straight at the tail
                            w_ram_we     = 1'b1;
                            w_ram_waddr  = r_tail;
                            w_ram_wdata  = w_in_entry;
                            n_tail       = ptr_inc(r_tail);
                            n_count      = r_count + 1'b1;
                            n_res_status = STATUS_OK;
                            n_state      = S_DONE;
                        end else begin
                            // Start the walk at the last stored entry
                            w_ram_raddr = ptr_dec(r_tail);
                            n_ptr       = ptr_dec(r_tail);
                            n_state     = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = STATUS_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            w_ram_raddr = r_head;
                            n_state     = S_DEQ;
                        end
                    end
                end
            end
            S_SCAN: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = ptr_inc(r_ptr);
                if ($signed(w_ram_rdata.prio) >= $signed(r_new.prio)) begin
                    // Insert behind the entry of equal or higher priority
                    w_ram_wdata  = r_new;
                    n_tail       = ptr_inc(r_tail);
                    n_count      = r_count + 1'b1;
                    n_res_status = STATUS_OK;
                    n_state      = S_DONE;
                end else begin
                    // Move the lower priority entry one place back
                    w_ram_wdata = w_ram_rdata;
                    if (r_ptr == r_head) begin
                        n_state = S_INS;
                    end else begin
                        w_ram_raddr = ptr_dec(r_ptr);
                        n_ptr       = ptr_dec(r_ptr);
                    end
                end
            end
            S_INS: begin
                // New entry goes to the front
                w_ram_we     = 1'b1;
                w_ram_waddr  = r_head;
                w_ram_wdata  = r_new;
                n_tail       = ptr_inc(r_tail);
                n_count      = r_count + 1'b1;
                n_res_status = STATUS_OK;
                n_state      = S_DONE;
            end
            S_DEQ: begin
                // Return the front entry and advance the head
                n_res_entry  = w_ram_rdata;
                n_res_status = STATUS_OK;
                n_head       = ptr_inc(r_head);
                n_count      = r_count - 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_entry;
    assign o_m_axis_tuser  = r_out_status;

    // Tail position implied by head and count, for checking
    logic [AW:0] w_tail_sum;
    logic [AW:0] w_tail_wrap;
    assign w_tail_sum  = {1'b0, r_head} + (AW + 1)'(r_count);
    assign w_tail_wrap = (w_tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                         ? w_tail_sum - (AW + 1)'(QUEUE_DEPTH) : w_tail_sum;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_tail_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tail_wrap[AW-1:0] == r_tail))
        else $error("tail pointer out of step with head and count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_axis_tready)
        else $error("second transaction taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == STATUS_OK ||
                             o_m_axis_tuser == STATUS_EMPTY ||
                             o_m_axis_tuser == STATUS_FULL))
        else $error("undefined status on output");

endmodule
